// ===== sv/sls_pkg.sv =====
// Shared types and constants of the scanline scheduler.
package sls_pkg;

    localparam int unsigned H_ACTIVE     = 640;
    localparam int unsigned HEADER_WORDS = 7;
    localparam int unsigned LB_HALF_WORDS = H_ACTIVE / 2;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [10:0] H_ACTIVE_V      = 11'(H_ACTIVE);
    localparam logic [10:0] HEADER_WORDS_V  = 11'(HEADER_WORDS);
    localparam logic [10:0] LB_HALF_WORDS_V = 11'(LB_HALF_WORDS);

    localparam logic [2:0] CFG_V_FRONT_PORCH  = 3'd0;
    localparam logic [2:0] CFG_V_SYNC_WIDTH   = 3'd1;
    localparam logic [2:0] CFG_V_BACK_PORCH   = 3'd2;
    localparam logic [2:0] CFG_V_ACTIVE_LINES = 3'd3;
    localparam logic [2:0] CFG_DOUBLE_BUFFER  = 3'd4;

    localparam logic [7:0] RST_V_FRONT_PORCH  = 8'd10;
    localparam logic [5:0] RST_V_SYNC_WIDTH   = 6'd2;
    localparam logic [7:0] RST_V_BACK_PORCH   = 8'd33;
    localparam logic [9:0] RST_V_ACTIVE_LINES = 10'd480;

    localparam logic [10:0] RST_LINE_COUNTER = 11'd2;
    localparam logic [10:0] FRAME_START_LINE = 11'd2;
    localparam logic [1:0]  RST_H_SCALE      = 2'd1;
    localparam logic [1:0]  RST_V_SCALE      = 2'd0;
    localparam logic [1:0]  H_SCALE_QUAD     = 2'd2;

    typedef enum logic [2:0] {
        KIND_VSYNC  = 3'd0,
        KIND_BLANK  = 3'd1,
        KIND_ACTIVE = 3'd2,
        KIND_PIXEL  = 3'd3,
        KIND_DROP   = 3'd4
    } sls_kind_t;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        sls_kind_t   kind;
        logic        buffer_half;
        logic [9:0]  source_line;
        logic        fetch_line;
        logic [9:0]  fetch_width;
        logic [8:0]  write_offset;
        logic [15:0] pixel_word;
        logic        render_request;
        logic        buffers_swapped;
        logic        dual_word;
    } sls_rec_t;

endpackage

// ===== sv/sls_front.sv =====
// Front end: configuration, line sequencing state and pixel classification.
module sls_front import sls_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic        op,
    input  logic [15:0] pixel_value,
    input  logic        render_done,
    input  logic        mode_request,
    input  logic [1:0]  new_h_scale,
    input  logic [1:0]  new_v_scale,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    output sls_rec_t    rec
);

    logic [7:0] v_front_porch_reg, v_front_porch_next;
    logic [5:0] v_sync_width_reg, v_sync_width_next;
    logic [7:0] v_back_porch_reg, v_back_porch_next;
    logic [9:0] v_active_lines_reg, v_active_lines_next;
    logic       double_buffer_reg, double_buffer_next;
    logic [8:0]  sync_end_reg, sync_end_next;
    logic [9:0]  blank_end_reg, blank_end_next;
    logic [10:0] total_reg, total_next;

    logic [10:0] line_counter_reg, line_counter_next;
    logic [1:0]  h_scale_reg, h_scale_next;
    logic [1:0]  v_scale_reg, v_scale_next;
    logic [1:0]  pending_h_reg, pending_h_next;
    logic [1:0]  pending_v_reg, pending_v_next;
    logic        mode_pending_reg, mode_pending_next;
    logic        render_pending_reg, render_pending_next;
    logic        display_select_reg, display_select_next;
    logic        fill_half_reg, fill_half_next;
    logic        fill_active_reg, fill_active_next;
    logic [9:0]  fill_index_reg, fill_index_next;

    // Configuration and the frame boundaries derived from it.
    always_comb begin
        v_front_porch_next  = v_front_porch_reg;
        v_sync_width_next   = v_sync_width_reg;
        v_back_porch_next   = v_back_porch_reg;
        v_active_lines_next = v_active_lines_reg;
        double_buffer_next  = double_buffer_reg;
        if (!aresetn) begin
            v_front_porch_next  = RST_V_FRONT_PORCH;
            v_sync_width_next   = RST_V_SYNC_WIDTH;
            v_back_porch_next   = RST_V_BACK_PORCH;
            v_active_lines_next = RST_V_ACTIVE_LINES;
            double_buffer_next  = 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_V_FRONT_PORCH:  v_front_porch_next  = cfg_data[7:0];
                CFG_V_SYNC_WIDTH:   v_sync_width_next   = cfg_data[5:0];
                CFG_V_BACK_PORCH:   v_back_porch_next   = cfg_data[7:0];
                CFG_V_ACTIVE_LINES: v_active_lines_next = cfg_data;
                CFG_DOUBLE_BUFFER:  double_buffer_next  = cfg_data[0];
                default: ;
            endcase
        end
        sync_end_next  = {1'b0, v_front_porch_next} + {3'b0, v_sync_width_next};
        blank_end_next = {1'b0, sync_end_next} + {2'b0, v_back_porch_next};
        total_next     = {1'b0, blank_end_next} + {1'b0, v_active_lines_next};
    end

    always_ff @(posedge aclk) begin
        v_front_porch_reg  <= v_front_porch_next;
        v_sync_width_reg   <= v_sync_width_next;
        v_back_porch_reg   <= v_back_porch_next;
        v_active_lines_reg <= v_active_lines_next;
        double_buffer_reg  <= double_buffer_next;
        sync_end_reg       <= sync_end_next;
        blank_end_reg      <= blank_end_next;
        total_reg          <= total_next;
    end

    logic [10:0] shifted_width;
    logic [9:0]  width;
    logic        quad;
    logic [10:0] words;
    logic [9:0]  taken;
    logic [10:0] offset_sum;
    logic [10:0] dl;
    logic [10:0] v_mask;
    logic [10:0] src_full;
    logic        fetch;
    logic [10:0] line_inc;

    always_comb begin
        shifted_width = H_ACTIVE_V >> h_scale_reg;
        width         = shifted_width[9:0];
        quad          = (h_scale_reg == H_SCALE_QUAD);
        words         = quad ? 11'd2 : 11'd1;
        taken         = quad ? (fill_index_reg >> 1) : fill_index_reg;
        offset_sum    = HEADER_WORDS_V + {1'b0, fill_index_reg};
        dl            = line_counter_reg - {1'b0, blank_end_reg};
        v_mask        = (11'd1 << v_scale_reg) - 11'd1;
        fetch         = ((dl & v_mask) == 11'd0);
        src_full      = dl >> v_scale_reg;
        line_inc      = line_counter_reg + 11'd1;

        line_counter_next   = line_counter_reg;
        h_scale_next        = h_scale_reg;
        v_scale_next        = v_scale_reg;
        pending_h_next      = pending_h_reg;
        pending_v_next      = pending_v_reg;
        mode_pending_next   = mode_pending_reg;
        render_pending_next = render_pending_reg;
        display_select_next = display_select_reg;
        fill_half_next      = fill_half_reg;
        fill_active_next    = fill_active_reg;
        fill_index_next     = fill_index_reg;
        rec                 = '0;

        // Software flags take effect before the line or pixel work.
        if (render_done) begin
            render_pending_next = 1'b0;
        end
        if (mode_request) begin
            mode_pending_next = 1'b1;
            pending_h_next    = new_h_scale;
            pending_v_next    = new_v_scale;
        end

        if (op) begin
            rec.buffer_half = fill_half_reg;
            if (!fill_active_reg || (taken >= width)
                    || ({1'b0, fill_index_reg} + words > LB_HALF_WORDS_V)) begin
                rec.kind = KIND_DROP;
            end else begin
                fill_index_next  = fill_index_reg + words[9:0];
                rec.kind         = KIND_PIXEL;
                rec.write_offset = offset_sum[8:0];
                rec.pixel_word   = pixel_value;
                rec.dual_word    = quad;
            end
        end else begin
            fill_active_next = 1'b0;
            if ((line_counter_reg >= {3'b0, v_front_porch_reg})
                    && (line_counter_reg < {2'b0, sync_end_reg})) begin
                rec.kind = KIND_VSYNC;
            end else if (line_counter_reg < {1'b0, blank_end_reg}) begin
                rec.kind = KIND_BLANK;
            end else begin
                rec.kind        = KIND_ACTIVE;
                rec.fetch_line  = fetch;
                rec.source_line = src_full[9:0];
                rec.buffer_half = src_full[0];
                rec.fetch_width = width;
                if (fetch) begin
                    fill_active_next = 1'b1;
                    fill_half_next   = src_full[0];
                    fill_index_next  = '0;
                end
            end

            line_counter_next = line_inc;
            if (line_inc == total_reg) begin
                line_counter_next = '0;
            end else if (line_inc == FRAME_START_LINE) begin
                if (!render_pending_next) begin
                    if (double_buffer_reg) begin
                        display_select_next = ~display_select_reg;
                        rec.buffers_swapped = 1'b1;
                    end
                    render_pending_next = 1'b1;
                end
                if (mode_pending_next) begin
                    h_scale_next      = pending_h_next;
                    v_scale_next      = pending_v_next;
                    mode_pending_next = 1'b0;
                    pending_h_next    = RST_H_SCALE;
                    pending_v_next    = RST_V_SCALE;
                end
            end
        end
        rec.render_request = render_pending_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_counter_reg   <= RST_LINE_COUNTER;
            h_scale_reg        <= RST_H_SCALE;
            v_scale_reg        <= RST_V_SCALE;
            pending_h_reg      <= RST_H_SCALE;
            pending_v_reg      <= RST_V_SCALE;
            mode_pending_reg   <= 1'b0;
            render_pending_reg <= 1'b1;
            display_select_reg <= 1'b0;
            fill_half_reg      <= 1'b0;
            fill_active_reg    <= 1'b0;
            fill_index_reg     <= '0;
        end else if (accept) begin
            line_counter_reg   <= line_counter_next;
            h_scale_reg        <= h_scale_next;
            v_scale_reg        <= v_scale_next;
            pending_h_reg      <= pending_h_next;
            pending_v_reg      <= pending_v_next;
            mode_pending_reg   <= mode_pending_next;
            render_pending_reg <= render_pending_next;
            display_select_reg <= display_select_next;
            fill_half_reg      <= fill_half_next;
            fill_active_reg    <= fill_active_next;
            fill_index_reg     <= fill_index_next;
        end
    end

endmodule

// ===== sv/sls_queue.sv =====
// Short record queue that decouples the front end from the result stage.
module sls_queue import sls_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  sls_rec_t push_rec,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output sls_rec_t head_rec
);

    sls_rec_t            entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/sls_back.sv =====
// Result stage: expands queued records into result transfers.
module sls_back import sls_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  sls_rec_t    head_rec,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output sls_rec_t    out_rec,
    output logic        m_tlast
);

    logic     valid_reg, valid_next;
    logic     second_reg, second_next;
    sls_rec_t rec_reg, rec_next;
    logic     last_reg, last_next;
    logic     load;

    // A quadruple-scale pixel stays at the head until its second word is loaded into the result register.
    always_comb begin
        load        = head_valid && (!valid_reg || m_tready);
        pop         = load && !(head_rec.dual_word && !second_reg);
        valid_next  = valid_reg;
        second_next = second_reg;
        rec_next    = rec_reg;
        last_next   = last_reg;
        if (load) begin
            valid_next = 1'b1;
            rec_next   = head_rec;
            last_next  = 1'b1;
            if (head_rec.dual_word && !second_reg) begin
                last_next   = 1'b0;
                second_next = 1'b1;
            end else if (second_reg) begin
                rec_next.write_offset = head_rec.write_offset + 9'd1;
                second_next           = 1'b0;
            end
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg  <= rec_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign out_rec  = rec_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== sv/scanline_scheduler_with_scaling.sv =====
// Top level of the scanline scheduler with pixel and line scaling.
//
// The scheduler sequences a video frame one line at a time and fills the line
// buffer from framebuffer pixels. An input transfer is either a line-finished
// event (s_tuser 0) or a framebuffer pixel (s_tuser 1). A line event returns
// one result that gives the kind of the next queued line (vsync blank, blank
// or active) and, for active lines, the buffer half, the source line and the
// fetch request. A pixel returns one line-buffer word, two words in a row when
// the horizontal scale is four, or one dropped-pixel result. One input
// transfer is taken per clock cycle while the record queue has room. The
// result port moves one result per cycle while m_tready is high, and a
// quadruple-scale pixel needs two results there. A four-entry record queue
// sits between the classifying front end and the result register, so input
// keeps flowing while a finished result waits for m_tready. A result passes
// through the queue and then the result register before m_tvalid offers it.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data; the
// user must do so while the block is idle, which the block does not enforce.
// A write takes effect on the next item; there is no read-back.
module scanline_scheduler_with_scaling import sls_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pixel_value[15:0], render_done[16], mode_request[17],
    // new_h_scale[19:18], new_v_scale[21:20], zero fill above
    input  logic [23:0] s_tdata,
    // op[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // buffer_half[0], source_line[10:1], fetch_line[11], fetch_width[21:12],
    // write_offset[30:22], pixel_word[46:31], render_request[47],
    // buffers_swapped[48], zero fill above
    output logic [55:0] m_tdata,
    // kind[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    logic     accept;
    logic     queue_full;
    sls_rec_t front_rec;
    logic     head_valid;
    sls_rec_t head_rec;
    logic     pop;
    sls_rec_t out_rec;

    // Every accepted transfer leaves exactly one record in the queue, so the
    // input side only has to see that the queue has room.
    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    sls_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .op           (s_tuser),
        .pixel_value  (s_tdata[15:0]),
        .render_done  (s_tdata[16]),
        .mode_request (s_tdata[17]),
        .new_h_scale  (s_tdata[19:18]),
        .new_v_scale  (s_tdata[21:20]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rec          (front_rec)
    );

    sls_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .push_rec   (front_rec),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    sls_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_rec    (out_rec),
        .m_tlast    (m_tlast)
    );

    // The internal word-pair flag is not part of the result payload.
    assign m_tuser = out_rec.kind;
    assign m_tdata = {7'd0,
                      out_rec.buffers_swapped,
                      out_rec.render_request,
                      out_rec.pixel_word,
                      out_rec.write_offset,
                      out_rec.fetch_width,
                      out_rec.fetch_line,
                      out_rec.source_line,
                      out_rec.buffer_half};

endmodule

// ===== sv/sls_checker.sv =====
// Port-level checker for the scanline scheduler, bound to the top level.
module sls_checker import sls_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // Nothing is offered in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Only the first word of a pixel pair may lack the last marker.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser == KIND_PIXEL)
        else $error("non-pixel result without last marker");

    // The second word of a pair follows at once, at the next buffer word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tlast && (m_tuser == KIND_PIXEL)
            && (m_tdata[30:22] == $past(m_tdata[30:22]) + 9'd1)
            && (m_tdata[46:31] == $past(m_tdata[46:31])))
        else $error("second word of a pixel pair is wrong");

endmodule

bind scanline_scheduler_with_scaling sls_checker u_sls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
